// ===== rtl/llcs_pkg.sv =====
// ----------------------------------------------------------------------------
// llcs_pkg
// Shared constants, types and a helper function of the layered LED color store.
// ----------------------------------------------------------------------------
package llcs_pkg;

   // Matrix geometry and field widths.
   localparam int LED_COUNT   = 64;
   localparam int LEVEL_COUNT = 8;
   localparam int LED_INDEX_W = 6;
   localparam int LEVEL_W     = 3;
   localparam int COLOR_W     = 8;
   localparam int MODE_W      = 3;
   localparam int MAP_W       = 8;

   // One RAM row holds every level color of one LED plus its occupied map.
   localparam int ROW_W = LEVEL_COUNT * COLOR_W + MAP_W;

   // Request modes.
   localparam logic [MODE_W-1:0] MODE_SET         = 3'd0;
   localparam logic [MODE_W-1:0] MODE_OVERWRITE   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_SET_DEFAULT = 3'd2;
   localparam logic [MODE_W-1:0] MODE_TOGGLE      = 3'd3;
   localparam logic [MODE_W-1:0] MODE_CLEAR       = 3'd4;

   // Register file layout.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_DISPLAY_ENABLED = 1'b0;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;   // take the request and start the row read
      logic exec;      // update the row and load the response register
   } llcs_cmd_type;

   // Highest set bit of an occupied map, 0 for an empty map.
   function automatic logic [LEVEL_W-1:0] highest_level(input logic [MAP_W-1:0] map);
      logic [LEVEL_W-1:0] h;
      h = '0;
      for (int b = 0; b < MAP_W; b++) begin
         if (map[b]) begin
            h = LEVEL_W'(b);
         end
      end
      return h;
   endfunction

endpackage

// ===== rtl/llcs_ram.sv =====
// ----------------------------------------------------------------------------
// llcs_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module llcs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port; read data holds while rd_en is low.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/llcs_ctrl.sv =====
// ----------------------------------------------------------------------------
// llcs_ctrl
// Controller of the color store: sequences the read-modify-write of one LED
// row per request and owns the response valid flag.
// ----------------------------------------------------------------------------
module llcs_ctrl
   import llcs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output llcs_cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      capture, exec;

   // A request is taken in the idle state; the row read data is ready in the next cycle.
   assign req_ready = (state_ff == ST_IDLE);
   assign capture   = req_valid && req_ready;
   // The update waits only while an older response is still held and not being taken.
   assign exec      = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_ready);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (capture) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (exec) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Response valid flag.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (exec) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign cmd.capture = capture;
   assign cmd.exec    = exec;

endmodule

// ===== rtl/llcs_dp.sv =====
// ----------------------------------------------------------------------------
// llcs_dp
// Datapath of the color store: request registers, the LED row RAM with its
// row valid bits, the mode logic and the response registers.
// ----------------------------------------------------------------------------
module llcs_dp
   import llcs_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  llcs_cmd_type           cmd,
   input  logic                   display_enabled,
   input  logic [MODE_W-1:0]      req_mode,
   input  logic [LED_INDEX_W-1:0] req_led_index,
   input  logic [LEVEL_W-1:0]     req_level,
   input  logic [COLOR_W-1:0]     req_color,
   output logic                   rsp_rejected,
   output logic [MAP_W-1:0]       rsp_level_map,
   output logic                   rsp_pixel_valid,
   output logic [LED_INDEX_W-1:0] rsp_pixel_index,
   output logic [COLOR_W-1:0]     rsp_pixel_color,
   output logic [LEVEL_W-1:0]     rsp_pixel_level
);

   // Captured request.
   logic [MODE_W-1:0]      mode_ff;
   logic [LED_INDEX_W-1:0] idx_ff;
   logic [LEVEL_W-1:0]     lvl_ff;
   logic [COLOR_W-1:0]     col_ff;

   // A row that was never written reads as zero.
   logic [LED_COUNT-1:0]   row_valid_ff;

   logic [ROW_W-1:0]       ram_rd_data;
   logic [ROW_W-1:0]       row;
   logic [ROW_W-1:0]       wr_row;
   logic                   wr_en;

   // Result of the mode logic.
   logic                   in_range;
   logic [MAP_W-1:0]       map, lvl_bit, new_map, map_out;
   logic [COLOR_W-1:0]     cur_col, new_col, pcol;
   logic [LEVEL_W-1:0]     hi, hi_left, plvl;
   logic                   empty, taken, rej, push, wr;

   // Response registers.
   logic                   rejected_ff;
   logic [MAP_W-1:0]       level_map_ff;
   logic                   pixel_valid_ff;
   logic [LED_INDEX_W-1:0] pixel_index_ff;
   logic [COLOR_W-1:0]     pixel_color_ff;
   logic [LEVEL_W-1:0]     pixel_level_ff;

   // Request capture.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff <= req_mode;
         idx_ff  <= req_led_index;
         lvl_ff  <= req_level;
         col_ff  <= req_color;
      end
   end

   // Row store, read on capture and written back on execute.
   llcs_ram #(
      .WIDTH (ROW_W),
      .DEPTH (LED_COUNT)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (idx_ff),
      .wr_data (wr_row),
      .rd_en   (cmd.capture),
      .rd_addr (req_led_index),
      .rd_data (ram_rd_data)
   );

   assign row = row_valid_ff[idx_ff] ? ram_rd_data : '0;

   // Mode logic over the fetched row.
   always_comb begin
      in_range = (mode_ff <= MODE_CLEAR) && (32'(idx_ff) < LED_COUNT)
                 && (32'(lvl_ff) < LEVEL_COUNT);
      map      = row[ROW_W-1 -: MAP_W];
      lvl_bit  = MAP_W'(1) << lvl_ff;
      cur_col  = row[lvl_ff*COLOR_W +: COLOR_W];
      empty    = (map == '0);
      taken    = ((map & lvl_bit) != '0);
      hi       = highest_level(map);
      rej      = 1'b0;
      map_out  = '0;
      push     = 1'b0;
      wr       = 1'b0;
      pcol     = col_ff;
      plvl     = lvl_ff;
      new_map  = map | lvl_bit;
      new_col  = col_ff;
      hi_left  = '0;
      if (in_range) begin
         case (mode_ff)
            MODE_SET, MODE_SET_DEFAULT: begin
               if (taken) begin
                  rej = 1'b1;
               end else begin
                  wr = 1'b1;
                  if (empty) begin
                     push    = 1'b1;
                     map_out = (mode_ff == MODE_SET) ? new_map : '0;
                  end else begin
                     push    = (hi < lvl_ff);
                     map_out = new_map;
                  end
               end
            end
            MODE_OVERWRITE: begin
               wr   = 1'b1;
               push = empty || taken || (hi < lvl_ff);
            end
            MODE_TOGGLE: begin
               wr      = 1'b1;
               new_col = cur_col ^ col_ff;
               pcol    = new_col;
               push    = 1'b1;
            end
            MODE_CLEAR: begin
               wr      = 1'b1;
               new_col = '0;
               new_map = map & ~lvl_bit;
               map_out = new_map;
               push    = 1'b1;
               hi_left = highest_level(new_map);
               // Show the highest remaining level, or black at the cleared one.
               if (new_map != '0) begin
                  pcol = row[hi_left*COLOR_W +: COLOR_W];
                  plvl = hi_left;
               end else begin
                  pcol = '0;
               end
            end
            default: begin
               wr = 1'b0;
            end
         endcase
      end
      if (!display_enabled) begin
         push = 1'b0;
      end
   end

   // Updated row for the write-back.
   always_comb begin
      wr_row = row;
      wr_row[lvl_ff*COLOR_W +: COLOR_W] = new_col;
      wr_row[ROW_W-1 -: MAP_W] = new_map;
   end

   assign wr_en = cmd.exec && wr;

   // Row valid bits, cleared at reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else if (wr_en) begin
         row_valid_ff[idx_ff] <= 1'b1;
      end
   end

   // Response registers; pixel fields read zero without a pixel update.
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         rejected_ff    <= rej;
         level_map_ff   <= map_out;
         pixel_valid_ff <= push;
         pixel_index_ff <= push ? idx_ff : '0;
         pixel_color_ff <= push ? pcol : '0;
         pixel_level_ff <= push ? plvl : '0;
      end
   end

   assign rsp_rejected    = rejected_ff;
   assign rsp_level_map   = level_map_ff;
   assign rsp_pixel_valid = pixel_valid_ff;
   assign rsp_pixel_index = pixel_index_ff;
   assign rsp_pixel_color = pixel_color_ff;
   assign rsp_pixel_level = pixel_level_ff;

endmodule

// ===== rtl/layered_led_color_store_unit.sv =====
// ----------------------------------------------------------------------------
// layered_led_color_store_unit
// Per-LED store of colors on eight priority levels with pixel update output.
// ----------------------------------------------------------------------------
// Usage:
// A request on the req_ channel names a mode, an LED, a level and a color.
// Each request yields exactly one response on the rsp_ channel: a rejected
// flag, a returned level map and, if display_enabled is set, any pixel update.
// Both channels use valid/ready; a transfer happens when both are high.
// The register display_enabled lies at byte address 0 of the APB port; the user
// must write it only while the block is idle, which the block does not enforce.
// A request accepted by the block has its row read into the RAM read register,
// then its result loaded into the response register once any older response is taken.
// A new request is taken only after the current one has updated its row, as set by the
// read-modify-write of one LED row in the row RAM (read, then update and
// write back). A response waiting in the output register does not block the
// next request from being accepted and its row from being read; the update
// then waits until the receiver takes the old response.
// Reset clears the controller, the register and the row valid bits, so every
// LED reads as empty right after reset without any clearing pass.
// ----------------------------------------------------------------------------
module layered_led_color_store_unit
   import llcs_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // Request channel.
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [MODE_W-1:0]      req_mode,
   input  logic [LED_INDEX_W-1:0] req_led_index,
   input  logic [LEVEL_W-1:0]     req_level,
   input  logic [COLOR_W-1:0]     req_color,
   // Response channel.
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_rejected,
   output logic [MAP_W-1:0]       rsp_level_map,
   output logic                   rsp_pixel_valid,
   output logic [LED_INDEX_W-1:0] rsp_pixel_index,
   output logic [COLOR_W-1:0]     rsp_pixel_color,
   output logic [LEVEL_W-1:0]     rsp_pixel_level,
   // Register port.
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [CSR_ADDR_W-1:0]  paddr,
   input  logic [CSR_DATA_W-1:0]  pwdata,
   output logic [CSR_DATA_W-1:0]  prdata,
   output logic                   pready
);

   llcs_cmd_type cmd;
   logic         display_enabled_ff, display_enabled_in;
   logic         reg_index;
   logic         reg_write;

   // Register decode: one 32-bit register per word.
   assign pready    = 1'b1;
   assign reg_index = paddr[CSR_ADDR_W-1];
   assign reg_write = psel && penable && pwrite && pready;

   always_comb begin
      display_enabled_in = display_enabled_ff;
      if (reg_write && (reg_index == REG_DISPLAY_ENABLED)) begin
         display_enabled_in = pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         display_enabled_ff <= 1'b0;
      end else begin
         display_enabled_ff <= display_enabled_in;
      end
   end

   // Read data; unused addresses return zero.
   assign prdata = (reg_index == REG_DISPLAY_ENABLED) ?
                   CSR_DATA_W'(display_enabled_ff) : '0;

   llcs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   llcs_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .display_enabled (display_enabled_ff),
      .req_mode        (req_mode),
      .req_led_index   (req_led_index),
      .req_level       (req_level),
      .req_color       (req_color),
      .rsp_rejected    (rsp_rejected),
      .rsp_level_map   (rsp_level_map),
      .rsp_pixel_valid (rsp_pixel_valid),
      .rsp_pixel_index (rsp_pixel_index),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_pixel_level (rsp_pixel_level)
   );

endmodule
